/* src/spot_pair_centroid_distance_assert.svh */
// ----------------------------------------------------------------------------
// spot pair centroid distance assertion macros
// concurrent assertion wrappers, compiled out when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef SPOT_PAIR_CENTROID_DISTANCE_ASSERT_SVH
`define SPOT_PAIR_CENTROID_DISTANCE_ASSERT_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define SPCD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define SPCD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define SPCD_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SPCD_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* src/spcd_pkg.sv */
// ----------------------------------------------------------------------------
// spcd_pkg
// widths and pipeline lengths of the spot pair centroid distance block
// ----------------------------------------------------------------------------
`default_nettype none
package spcd_pkg;
    localparam int FRAC_BITS = 8;
    localparam int SUM_W     = 32;
    localparam int CENT_W    = 24;
    localparam int ORG_W     = 12;
    localparam int ROI_W     = 6;
    localparam int DIST_W    = 25;
    localparam int POS_W     = 25;
    localparam int SQ_W      = 2 * POS_W;
    localparam int RAD_W     = 2 * (DIST_W + 1);
    localparam int ROOT_W    = RAD_W / 2;
    localparam int SREM_W    = ROOT_W + 2;
    localparam int HI_W      = CENT_W - FRAC_BITS;
    localparam int DIV_LAT   = CENT_W + 1;
    localparam int SQRT_LAT  = ROOT_W + 1;
    localparam int POST_LAT  = 3 + SQRT_LAT;
    localparam int TOT_LAT   = DIV_LAT + POST_LAT;

    typedef struct packed {
        logic [ROI_W-1:0] roi;
        logic             two;
        logic [ORG_W-1:0] lox;
        logic [ORG_W-1:0] loy;
        logic [ORG_W-1:0] rox;
        logic [ORG_W-1:0] roy;
    } t_side;

    typedef struct packed {
        logic [ROI_W-1:0]  roi;
        logic              two;
        logic              zero;
        logic [CENT_W-1:0] lcx;
        logic [CENT_W-1:0] lcy;
        logic [CENT_W-1:0] rcx;
        logic [CENT_W-1:0] rcy;
    } t_post;
endpackage
`default_nettype wire

/* src/spot_pair_centroid_distance.sv */
// ----------------------------------------------------------------------------
// spot_pair_centroid_distance
// per-region spot centroids and distance between the two global centres
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall, one region record per beat
//   output channel: o_valid / i_stall, one result beat per input beat
//   four divider lanes (left x, left y, right x, right y) run side by side,
//   each a 24-stage restoring divider with an entry register
//   a merge stage forms global centres and differences, then squares, sums,
//   and a 26-stage square root produce the distance
//   throughput: one beat per cycle while the output is not stalled, set by the
//   bit-per-stage divider and root pipelines
//   reset clears all valid flags; payload registers are left as they are
//   when the output beat is stalled the whole pipeline holds, and o_stall
//   rises in the same cycle so no beat is lost
// ----------------------------------------------------------------------------
`default_nettype none
module spot_pair_centroid_distance (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic [spcd_pkg::ROI_W-1:0]      i_roi_index,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_left_sum_x,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_left_sum_y,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_left_weight,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_right_sum_x,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_right_sum_y,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_right_weight,
    input  wire logic [spcd_pkg::ORG_W-1:0]      i_left_origin_x,
    input  wire logic [spcd_pkg::ORG_W-1:0]      i_left_origin_y,
    input  wire logic [spcd_pkg::ORG_W-1:0]      i_right_origin_x,
    input  wire logic [spcd_pkg::ORG_W-1:0]      i_right_origin_y,
    input  wire logic                            i_two_spots,
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic      [spcd_pkg::ROI_W-1:0]      o_result_roi,
    output logic      [spcd_pkg::CENT_W-1:0]     o_left_cx,
    output logic      [spcd_pkg::CENT_W-1:0]     o_left_cy,
    output logic      [spcd_pkg::CENT_W-1:0]     o_right_cx,
    output logic      [spcd_pkg::CENT_W-1:0]     o_right_cy,
    output logic      [spcd_pkg::DIST_W-1:0]     o_spot_distance,
    output logic                                 o_zero_weight
);
`include "spot_pair_centroid_distance_assert.svh"

    localparam int PW = spcd_pkg::POS_W;

    // global advance: hold everything while a finished beat is refused
    logic w_en;
    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    logic [spcd_pkg::TOT_LAT-1:0] r_vld;

    // sideband that travels next to the divider lanes
    spcd_pkg::t_side r_side [0:spcd_pkg::DIV_LAT-1];
    spcd_pkg::t_side w_side;
    assign w_side = '{roi: i_roi_index, two: i_two_spots,
                      lox: i_left_origin_x, loy: i_left_origin_y,
                      rox: i_right_origin_x, roy: i_right_origin_y};

    // divider lanes
    logic [spcd_pkg::CENT_W-1:0] w_q [4];
    logic                        w_z [4];
    logic [spcd_pkg::SUM_W-1:0]  w_num [4];
    logic [spcd_pkg::SUM_W-1:0]  w_den [4];
    assign w_num[0] = i_left_sum_x;
    assign w_num[1] = i_left_sum_y;
    assign w_num[2] = i_right_sum_x;
    assign w_num[3] = i_right_sum_y;
    assign w_den[0] = i_left_weight;
    assign w_den[1] = i_left_weight;
    assign w_den[2] = i_right_weight;
    assign w_den[3] = i_right_weight;

    for (genvar g = 0; g < 4; g++) begin : g_lane
        spcd_div u_div (
            .i_clk    (i_clk),
            .i_en     (w_en),
            .i_sum    (w_num[g]),
            .i_weight (w_den[g]),
            .o_quot   (w_q[g]),
            .o_zero   (w_z[g])
        );
    end

    // merge: global centres and their absolute differences
    spcd_pkg::t_side w_sd;
    logic [PW-1:0] w_glx, w_gly, w_grx, w_gry;
    assign w_sd  = r_side[spcd_pkg::DIV_LAT-1];
    assign w_glx = PW'({w_sd.lox, {spcd_pkg::FRAC_BITS{1'b0}}}) + PW'(w_q[0]);
    assign w_gly = PW'({w_sd.loy, {spcd_pkg::FRAC_BITS{1'b0}}}) + PW'(w_q[1]);
    assign w_grx = PW'({w_sd.rox, {spcd_pkg::FRAC_BITS{1'b0}}}) + PW'(w_q[2]);
    assign w_gry = PW'({w_sd.roy, {spcd_pkg::FRAC_BITS{1'b0}}}) + PW'(w_q[3]);

    logic [PW-1:0]             r_dx, r_dy;
    logic [spcd_pkg::SQ_W-1:0] r_dx2, r_dy2;
    logic [spcd_pkg::RAD_W-1:0] r_sum;

    spcd_pkg::t_post r_post [0:spcd_pkg::POST_LAT-1];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_side;
            for (int s = 1; s < spcd_pkg::DIV_LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
            r_dx  <= (w_grx >= w_glx) ? (w_grx - w_glx) : (w_glx - w_grx);
            r_dy  <= (w_gry >= w_gly) ? (w_gry - w_gly) : (w_gly - w_gry);
            r_post[0] <= '{roi: w_sd.roi, two: w_sd.two,
                           zero: w_z[0] || w_z[2],
                           lcx: w_q[0], lcy: w_q[1], rcx: w_q[2], rcy: w_q[3]};
            r_dx2 <= r_dx * r_dx;
            r_dy2 <= r_dy * r_dy;
            r_sum <= spcd_pkg::RAD_W'(r_dx2) + spcd_pkg::RAD_W'(r_dy2);
            for (int s = 1; s < spcd_pkg::POST_LAT; s++) begin
                r_post[s] <= r_post[s-1];
            end
        end
    end

    logic [spcd_pkg::DIST_W-1:0] w_root;
    spcd_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (r_sum),
        .o_root (w_root)
    );

    // valid line and output register
    spcd_pkg::t_post w_pe;
    assign w_pe = r_post[spcd_pkg::POST_LAT-1];

    logic r_out_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_vld     <= {r_vld[spcd_pkg::TOT_LAT-2:0], i_valid};
            r_out_vld <= r_vld[spcd_pkg::TOT_LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_result_roi    <= w_pe.roi;
            o_left_cx       <= w_pe.lcx;
            o_left_cy       <= w_pe.lcy;
            o_right_cx      <= w_pe.rcx;
            o_right_cy      <= w_pe.rcy;
            o_zero_weight   <= w_pe.zero;
            // single spot forces a zero distance
            o_spot_distance <= w_pe.two ? w_root : '0;
        end
    end

    assign o_valid = r_out_vld;

    `SPCD_ASSERT_IMP(a_stall_needs_out, i_clk, i_rst_n, o_stall, o_valid)
    `SPCD_ASSERT_NXT(a_hold_when_stalled, i_clk, i_rst_n, o_stall, $stable(r_vld))
    `SPCD_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, r_vld[0])
endmodule
`default_nettype wire

/* src/spcd_div.sv */
// ----------------------------------------------------------------------------
// spcd_div
// pipelined restoring divider, one quotient bit per stage, saturating
// ----------------------------------------------------------------------------
`default_nettype none
module spcd_div (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_sum,
    input  wire logic [spcd_pkg::SUM_W-1:0]      i_weight,
    output logic      [spcd_pkg::CENT_W-1:0]     o_quot,
    output logic                                 o_zero
);
    localparam int N = spcd_pkg::CENT_W;
    localparam int W = spcd_pkg::SUM_W;

    logic [W-1:0] r_rem  [0:N];
    logic [N-1:0] r_num  [0:N];
    logic [W-1:0] r_w    [0:N];
    logic [N-1:0] r_q    [0:N];
    logic         r_sat  [0:N];
    logic         r_zero [0:N];

    logic [W-1:0] n_rem [N];
    logic [N-1:0] n_q   [N];
    logic [W:0]   w_t   [N];
    logic         w_ge  [N];

    always_comb begin
        for (int s = 0; s < N; s++) begin
            w_t[s]   = {r_rem[s], r_num[s][N-1]};
            w_ge[s]  = (w_t[s] >= {1'b0, r_w[s]});
            n_rem[s] = w_ge[s] ? W'(w_t[s] - {1'b0, r_w[s]}) : w_t[s][W-1:0];
            n_q[s]   = {r_q[s][N-2:0], w_ge[s]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= W'(i_sum[W-1:spcd_pkg::HI_W]);
            r_num[0]  <= {i_sum[spcd_pkg::HI_W-1:0], {spcd_pkg::FRAC_BITS{1'b0}}};
            r_w[0]    <= i_weight;
            r_q[0]    <= '0;
            r_sat[0]  <= (W'(i_sum[W-1:spcd_pkg::HI_W]) >= i_weight);
            r_zero[0] <= (i_weight == '0);
            for (int s = 0; s < N; s++) begin
                r_rem[s+1]  <= n_rem[s];
                r_num[s+1]  <= {r_num[s][N-2:0], 1'b0};
                r_w[s+1]    <= r_w[s];
                r_q[s+1]    <= n_q[s];
                r_sat[s+1]  <= r_sat[s];
                r_zero[s+1] <= r_zero[s];
            end
        end
    end

    // zero weight wins over saturation
    assign o_quot = r_zero[N] ? '0 : (r_sat[N] ? '1 : r_q[N]);
    assign o_zero = r_zero[N];
endmodule
`default_nettype wire

/* src/spcd_sqrt.sv */
// ----------------------------------------------------------------------------
// spcd_sqrt
// pipelined integer square root, one root bit per stage, saturating
// ----------------------------------------------------------------------------
`default_nettype none
module spcd_sqrt (
    input  wire logic                            i_clk,
    input  wire logic                            i_en,
    input  wire logic [spcd_pkg::RAD_W-1:0]      i_rad,
    output logic      [spcd_pkg::DIST_W-1:0]     o_root
);
    localparam int N  = spcd_pkg::ROOT_W;
    localparam int RW = spcd_pkg::SREM_W;
    localparam int AW = spcd_pkg::RAD_W;

    logic [AW-1:0] r_rad  [0:N];
    logic [RW-1:0] r_rem  [0:N];
    logic [N-1:0]  r_root [0:N];

    logic [RW+1:0] w_t   [N];
    logic [RW+1:0] w_try [N];
    logic          w_ge  [N];
    logic [RW-1:0] n_rem [N];

    always_comb begin
        for (int s = 0; s < N; s++) begin
            w_t[s]   = {r_rem[s], r_rad[s][AW-1:AW-2]};
            w_try[s] = (RW+2)'({r_root[s], 2'b01});
            w_ge[s]  = (w_t[s] >= w_try[s]);
            n_rem[s] = w_ge[s] ? RW'(w_t[s] - w_try[s]) : w_t[s][RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rad[0]  <= i_rad;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
            for (int s = 0; s < N; s++) begin
                r_rad[s+1]  <= {r_rad[s][AW-3:0], 2'b00};
                r_rem[s+1]  <= n_rem[s];
                r_root[s+1] <= {r_root[s][N-2:0], w_ge[s]};
            end
        end
    end

    assign o_root = r_root[N][N-1] ? '1 : r_root[N][spcd_pkg::DIST_W-1:0];
endmodule
`default_nettype wire
